// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define SDL_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("sorted_delay_list: assertion failed");

// Check that a condition implies another in the same cycle.
`define SDL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sorted_delay_list: assertion failed");

// Check that a condition implies another in the following cycle.
`define SDL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sorted_delay_list: assertion failed");

`endif

// File: rtl/sdl_pkg.sv
`default_nettype none

package sdl_pkg;

    localparam int ID_BITS       = 4;
    localparam int NUM_IDS       = 2 ** ID_BITS;
    localparam int IN_KEY_BITS   = 32;
    localparam int CNT_BITS      = 5;
    localparam int OP_BITS       = 2;
    localparam int ERR_BITS      = 2;
    localparam int MAX_ITEMS_DEF = 16;
    localparam int KEY_BITS_DEF  = 32;

    typedef enum logic [OP_BITS-1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_TAIL   = 2'd2,
        OP_REMOVE = 2'd3
    } t_op;

    typedef enum logic [ERR_BITS-1:0] {
        ERR_OK       = 2'd0,
        ERR_LISTED   = 2'd1,
        ERR_UNLISTED = 2'd2
    } t_err;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_OUT
    } t_state;

    // Operation wave that ripples down the cell chain.
    typedef struct packed {
        logic                vld;
        t_op                 op;
        logic                itm;
        logic                hit;
        logic [ID_BITS-1:0]  id;
    } t_tok;

    typedef struct packed {
        logic               vld;
        logic [ID_BITS-1:0] id;
    } t_ent;

    function automatic int f_ncell(input int max_items);
        return (max_items < NUM_IDS) ? max_items : NUM_IDS;
    endfunction

endpackage

`default_nettype wire

// File: rtl/sdl_ifs.sv
`default_nettype none

interface sdl_in_if;
    import sdl_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OP_BITS-1:0]     operation;
    logic [ID_BITS-1:0]     item_id;
    logic [IN_KEY_BITS-1:0] item_key;

    modport source (output valid, operation, item_id, item_key, input ready);
    modport sink   (input valid, operation, item_id, item_key, output ready);
endinterface

interface sdl_out_if;
    import sdl_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CNT_BITS-1:0]    item_count;
    logic [ID_BITS-1:0]     head_item;
    logic [IN_KEY_BITS-1:0] head_key;
    logic                   list_empty;
    logic [ERR_BITS-1:0]    error_code;

    modport source (output valid, item_count, head_item, head_key, list_empty,
                    error_code, input ready);
    modport sink   (input valid, item_count, head_item, head_key, list_empty,
                    error_code, output ready);
endinterface

`default_nettype wire

// File: rtl/sdl_cell.sv
`default_nettype none

module sdl_cell #(
    parameter int KEY_BITS = sdl_pkg::KEY_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire sdl_pkg::t_tok       i_tok,
    input  wire logic [KEY_BITS-1:0] i_tok_key,
    output sdl_pkg::t_tok            o_tok,
    output logic [KEY_BITS-1:0]      o_tok_key,
    input  wire logic                i_rgive,
    input  wire sdl_pkg::t_ent       i_rent,
    input  wire logic [KEY_BITS-1:0] i_rent_key,
    output sdl_pkg::t_ent            o_ent,
    output logic [KEY_BITS-1:0]      o_ent_key,
    output logic                     o_give
);
    import sdl_pkg::*;

    logic                r_vld;
    logic [ID_BITS-1:0]  r_id;
    logic [KEY_BITS-1:0] r_key;
    t_tok                r_tok;
    logic [KEY_BITS-1:0] r_tok_key;

    logic                n_vld;
    logic [ID_BITS-1:0]  n_id;
    logic [KEY_BITS-1:0] n_key;
    t_tok                n_tok;
    logic [KEY_BITS-1:0] n_tok_key;

    logic w_place;

    assign w_place = i_tok.itm && (i_tok.hit || !r_vld ||
                     ((i_tok.op == OP_INSERT) && (r_key > i_tok_key)));

    always_comb begin
        n_vld     = r_vld;
        n_id      = r_id;
        n_key     = r_key;
        n_tok     = i_tok;
        n_tok_key = i_tok_key;
        if (i_rgive) begin
            n_vld = i_rent.vld;
            n_id  = i_rent.id;
            n_key = i_rent_key;
        end else if (i_tok.vld) begin
            case (i_tok.op)
                OP_CLEAR: begin
                    n_vld = 1'b0;
                end
                OP_INSERT, OP_TAIL: begin
                    // take the item and pass the displaced one on
                    if (w_place) begin
                        n_vld     = 1'b1;
                        n_id      = i_tok.id;
                        n_key     = i_tok_key;
                        n_tok.id  = r_id;
                        n_tok.itm = r_vld;
                        n_tok.hit = 1'b1;
                        n_tok_key = r_key;
                    end
                end
                OP_REMOVE: begin
                    // drop the match, then close the gap from the right
                    if (i_tok.hit) begin
                        n_vld = 1'b0;
                    end else if (r_vld && (r_id == i_tok.id)) begin
                        n_vld     = 1'b0;
                        n_tok.hit = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_tok <= '0;
        end else begin
            r_vld <= n_vld;
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id      <= n_id;
        r_key     <= n_key;
        r_tok_key <= n_tok_key;
    end

    assign o_tok     = r_tok;
    assign o_tok_key = r_tok_key;
    assign o_ent     = '{vld: r_vld, id: r_id};
    assign o_ent_key = r_key;
    assign o_give    = i_tok.vld && (i_tok.op == OP_REMOVE) && i_tok.hit;

endmodule

`default_nettype wire

// File: rtl/sdl_seq.sv
`default_nettype none
`include "assert_macros.svh"

module sdl_seq #(
    parameter int MAX_ITEMS = sdl_pkg::MAX_ITEMS_DEF,
    parameter int KEY_BITS  = sdl_pkg::KEY_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    sdl_in_if.sink                   i_in,
    sdl_out_if.source                o_out,
    output sdl_pkg::t_tok            o_tok,
    output logic [KEY_BITS-1:0]      o_tok_key,
    input  wire sdl_pkg::t_ent       i_head,
    input  wire logic [KEY_BITS-1:0] i_head_key,
    input  wire logic                i_done
);
    import sdl_pkg::*;

    localparam int NCELL = f_ncell(MAX_ITEMS);

    t_state               r_state;
    t_state               n_state;
    logic [NUM_IDS-1:0]   r_in_list;
    logic [NUM_IDS-1:0]   n_in_list;
    logic [CNT_BITS-1:0]  r_cnt;
    logic [CNT_BITS-1:0]  n_cnt;
    t_tok                 r_tok;
    t_tok                 n_tok;
    logic [KEY_BITS-1:0]  r_tok_key;
    logic [KEY_BITS-1:0]  n_tok_key;

    logic [CNT_BITS-1:0]    r_o_cnt;
    logic [ID_BITS-1:0]     r_o_id;
    logic [IN_KEY_BITS-1:0] r_o_key;
    logic                   r_o_empty;
    t_err                   r_o_err;
    t_err                   n_o_err;

    t_op  w_op;
    t_err w_err;
    logic w_cap;

    assign w_op = t_op'(i_in.operation);

    always_comb begin
        w_err = ERR_OK;
        if (w_op != OP_CLEAR) begin
            if (int'(i_in.item_id) >= MAX_ITEMS) begin
                w_err = ERR_UNLISTED;
            end else if (w_op == OP_REMOVE) begin
                if (!r_in_list[i_in.item_id]) begin
                    w_err = ERR_UNLISTED;
                end
            end else if (r_in_list[i_in.item_id]) begin
                w_err = ERR_LISTED;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_in_list = r_in_list;
        n_cnt     = r_cnt;
        n_tok     = '0;
        n_tok_key = r_tok_key;
        n_o_err   = ERR_OK;
        w_cap     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_tok_key = KEY_BITS'(i_in.item_key);
                    n_o_err   = w_err;
                    if (w_err != ERR_OK) begin
                        w_cap   = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_tok.vld = 1'b1;
                        n_tok.op  = w_op;
                        n_tok.itm = 1'b1;
                        n_tok.hit = 1'b0;
                        n_tok.id  = i_in.item_id;
                        n_state   = S_RUN;
                        case (w_op)
                            OP_CLEAR: begin
                                n_in_list = '0;
                                n_cnt     = '0;
                            end
                            OP_REMOVE: begin
                                n_in_list[i_in.item_id] = 1'b0;
                                n_cnt = r_cnt - CNT_BITS'(1);
                            end
                            default: begin
                                n_in_list[i_in.item_id] = 1'b1;
                                n_cnt = r_cnt + CNT_BITS'(1);
                            end
                        endcase
                    end
                end
            end
            S_RUN: begin
                if (i_done) begin
                    w_cap   = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_in_list <= '0;
            r_cnt     <= '0;
            r_tok     <= '0;
        end else begin
            r_state   <= n_state;
            r_in_list <= n_in_list;
            r_cnt     <= n_cnt;
            r_tok     <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok_key <= n_tok_key;
        if (w_cap) begin
            r_o_cnt   <= n_cnt;
            r_o_err   <= n_o_err;
            r_o_empty <= !i_head.vld;
            r_o_id    <= i_head.vld ? i_head.id : '0;
            r_o_key   <= i_head.vld ? IN_KEY_BITS'(i_head_key) : '1;
        end
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = (r_state == S_OUT);
    assign o_out.item_count = r_o_cnt;
    assign o_out.head_item  = r_o_id;
    assign o_out.head_key   = r_o_key;
    assign o_out.list_empty = r_o_empty;
    assign o_out.error_code = r_o_err;
    assign o_tok            = r_tok;
    assign o_tok_key        = r_tok_key;

    `SDL_ASSERT_ALWAYS(a_cnt_matches, i_clk, i_rst_n, $countones(r_in_list) == int'(r_cnt))
    `SDL_ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, int'(r_cnt) <= NCELL)
    `SDL_ASSERT_IMPL(a_done_in_run, i_clk, i_rst_n, i_done, r_state == S_RUN)
    `SDL_ASSERT_NEXT(a_launch_once, i_clk, i_rst_n, r_tok.vld, !r_tok.vld && r_state == S_RUN)

endmodule

`default_nettype wire

// File: rtl/sorted_delay_list.sv
// Ordered list of up to min(MAX_ITEMS, 16) item identifiers with clear, sorted
// insert, tail insert and remove. The list lives in a chain of cells, head
// first; an accepted request travels down the chain one cell per clock, and
// its result is registered once the request has passed the last cell.
// Rejected requests (item already listed, item not listed, identifier out of
// range) leave the list as is and are answered in the next cycle. A sorted
// insert goes before the first listed item whose key is strictly greater; a
// tail insert always goes last. Results wait in an output register; no new
// request is taken until the result word has been taken.
`default_nettype none

module sorted_delay_list #(
    parameter int MAX_ITEMS = sdl_pkg::MAX_ITEMS_DEF,
    parameter int KEY_BITS  = sdl_pkg::KEY_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sdl_in_if.sink    i_in,
    sdl_out_if.source o_out
);
    import sdl_pkg::*;

    localparam int NCELL = f_ncell(MAX_ITEMS);

    t_tok                w_tok     [NCELL+1];
    logic [KEY_BITS-1:0] w_tok_key [NCELL+1];
    t_ent                w_ent     [NCELL+1];
    logic [KEY_BITS-1:0] w_ent_key [NCELL+1];
    logic                w_give    [NCELL+1];

    assign w_ent[NCELL]     = '0;
    assign w_ent_key[NCELL] = '0;
    assign w_give[NCELL]    = 1'b0;

    sdl_seq #(
        .MAX_ITEMS (MAX_ITEMS),
        .KEY_BITS  (KEY_BITS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_out      (o_out),
        .o_tok      (w_tok[0]),
        .o_tok_key  (w_tok_key[0]),
        .i_head     (w_ent[0]),
        .i_head_key (w_ent_key[0]),
        .i_done     (w_tok[NCELL].vld)
    );

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        sdl_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_tok      (w_tok[g]),
            .i_tok_key  (w_tok_key[g]),
            .o_tok      (w_tok[g+1]),
            .o_tok_key  (w_tok_key[g+1]),
            .i_rgive    (w_give[g+1]),
            .i_rent     (w_ent[g+1]),
            .i_rent_key (w_ent_key[g+1]),
            .o_ent      (w_ent[g]),
            .o_ent_key  (w_ent_key[g]),
            .o_give     (w_give[g])
        );
    end

endmodule

`default_nettype wire
